FILE: hdl/blppr_pkg.sv
// ----------------------------------------------------------------------------
// blppr_pkg
// Shared types and codes for the bounded list core and its cell row.
// ----------------------------------------------------------------------------
package blppr_pkg;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_READ   = 2'd2,
        OP_REMOVE = 2'd3
    } blppr_op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } blppr_status_t;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'd0,
        FSM_EXEC = 2'd1,
        FSM_OUT  = 2'd2
    } blppr_fsm_t;

    // Broadcast to every cell during the execute cycle
    typedef struct packed {
        logic      exec;
        blppr_op_t op;
        logic      full;
    } blppr_ctrl_t;

    localparam int unsigned CAP_WIDTH   = 5;
    localparam int unsigned POS_WIDTH   = 4;
    localparam int unsigned COUNT_WIDTH = 5;
    localparam logic [CAP_WIDTH-1:0] CAP_RESET = 5'd16;

endpackage

FILE: hdl/blppr_cell.sv
// ----------------------------------------------------------------------------
// blppr_cell
// One list entry: takes a pushed handle at the tail, matches a handle for
// removal and takes its upper neighbour's entry when the gap closes.
// ----------------------------------------------------------------------------
module blppr_cell
    import blppr_pkg::*;
#(
    parameter int unsigned HANDLE_WIDTH = 32,
    parameter int unsigned CW           = 5,
    parameter int unsigned INDEX        = 0
) (
    input  logic                    aclk,
    input  blppr_ctrl_t             ctrl,
    input  logic [HANDLE_WIDTH-1:0] key,
    input  logic [CW-1:0]           count,
    input  logic [HANDLE_WIDTH-1:0] upper_data,
    input  logic                    found_in,
    output logic [HANDLE_WIDTH-1:0] data,
    output logic                    found_out
);

    localparam logic [CW-1:0] MY_INDEX = CW'(INDEX);

    logic [HANDLE_WIDTH-1:0] data_reg;
    logic [HANDLE_WIDTH-1:0] data_next;
    logic                    in_use;
    logic                    take_push;
    logic                    take_shift;

    assign in_use     = (MY_INDEX < count);
    assign found_out  = found_in | (in_use & (data_reg == key));
    assign take_push  = ctrl.exec & (ctrl.op == OP_PUSH) & ~ctrl.full & (MY_INDEX == count);
    assign take_shift = ctrl.exec & (ctrl.op == OP_REMOVE) & found_out;

    always_comb begin
        priority if (take_push) begin
            data_next = key;
        end else if (take_shift) begin
            data_next = upper_data;
        end else begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

FILE: hdl/bounded_list_push_pop_remove_core.sv
// ----------------------------------------------------------------------------
// bounded_list_push_pop_remove_core
// Bounded ordered list of handles with push, pop, read and remove by value.
// ----------------------------------------------------------------------------
// One operation is in flight at a time. The input transfer registers the
// operation. In the next cycle the row of DEPTH cells compares, shifts and
// updates while the result register loads. The result is offered in the cycle
// after that. Input is ready again only in the cycle after the output
// transfer: the three-state controller holds off input until the result has
// been transferred, so no new item is taken while one is in flight. The
// cells need no clearing after reset; only entries below the count are ever
// read.
// ----------------------------------------------------------------------------
module bounded_list_push_pop_remove_core
    import blppr_pkg::*;
#(
    parameter int unsigned DEPTH        = 16,
    parameter int unsigned HANDLE_WIDTH = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CAP_WIDTH-1:0]    cfg_wr_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_op,
    input  logic [HANDLE_WIDTH-1:0] s_item_value,
    input  logic [POS_WIDTH-1:0]    s_position,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [HANDLE_WIDTH-1:0] m_result_value,
    output logic [1:0]              m_status,
    output logic [COUNT_WIDTH-1:0]  m_entry_count
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned W  = (CW > COUNT_WIDTH) ? CW : COUNT_WIDTH;
    localparam int unsigned RN = (DEPTH < (1 << POS_WIDTH)) ? DEPTH : (1 << POS_WIDTH);
    localparam logic [W-1:0]  DEPTH_W = W'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    blppr_fsm_t state_reg, state_next;
    logic       exec;

    logic [CAP_WIDTH-1:0]    capacity_reg;
    logic [CW-1:0]           count_reg, count_next;
    blppr_op_t               op_reg;
    logic [HANDLE_WIDTH-1:0] key_reg;
    logic [POS_WIDTH-1:0]    pos_reg;

    logic [HANDLE_WIDTH-1:0] result_reg, result_next;
    blppr_status_t           status_reg, status_next;
    logic [COUNT_WIDTH-1:0]  entry_count_reg;

    logic [HANDLE_WIDTH-1:0] cell_data [DEPTH];
    logic [DEPTH:0]          found;
    logic [HANDLE_WIDTH-1:0] pop_data, rd_data;
    logic [W-1:0]            count_w, count_next_w, pos_w;
    logic                    full;
    blppr_ctrl_t             ctrl;

    // ---------------- control ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE: if (s_valid) state_next = FSM_EXEC;
            FSM_EXEC: state_next = FSM_OUT;
            FSM_OUT:  if (m_ready) state_next = FSM_IDLE;
            default:  state_next = FSM_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        exec    = 1'b0;
        unique case (state_reg)
            FSM_IDLE: s_ready = 1'b1;
            FSM_EXEC: exec    = 1'b1;
            FSM_OUT:  m_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= FSM_IDLE;
            capacity_reg <= CAP_RESET;
            count_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                capacity_reg <= cfg_wr_data;
            end
            if (exec) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg  <= blppr_op_t'(s_op);
            key_reg <= s_item_value;
            pos_reg <= s_position;
        end
        if (exec) begin
            result_reg      <= result_next;
            status_reg      <= status_next;
            entry_count_reg <= count_next_w[COUNT_WIDTH-1:0];
        end
    end

    // ---------------- cell row ----------------
    assign count_w = W'(count_reg);
    assign pos_w   = W'(pos_reg);
    assign full    = (count_w >= DEPTH_W) || (count_w >= W'(capacity_reg));

    assign ctrl.exec = exec;
    assign ctrl.op   = op_reg;
    assign ctrl.full = full;

    assign found[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        blppr_cell #(
            .HANDLE_WIDTH (HANDLE_WIDTH),
            .CW           (CW),
            .INDEX        (i)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .key        (key_reg),
            .count      (count_reg),
            .upper_data (cell_data[(i == DEPTH - 1) ? i : i + 1]),
            .found_in   (found[i]),
            .data       (cell_data[i]),
            .found_out  (found[i+1])
        );
    end

    // Tail entry and positional read
    always_comb begin
        pop_data = '0;
        rd_data  = '0;
        for (int j = 0; j < DEPTH; j++) begin
            if (count_reg == CW'(j + 1)) begin
                pop_data = pop_data | cell_data[j];
            end
        end
        for (int j = 0; j < RN; j++) begin
            if (pos_reg == POS_WIDTH'(j)) begin
                rd_data = rd_data | cell_data[j];
            end
        end
    end

    // ---------------- result ----------------
    always_comb begin
        count_next  = count_reg;
        result_next = '0;
        status_next = ST_OK;
        unique case (op_reg)
            OP_PUSH: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    count_next = count_reg + ONE_C;
                end
            end
            OP_POP: begin
                if (count_reg == '0) begin
                    status_next = ST_MISS;
                end else begin
                    count_next  = count_reg - ONE_C;
                    result_next = pop_data;
                end
            end
            OP_READ: begin
                if ((pos_w < count_w) && (pos_w < DEPTH_W)) begin
                    result_next = rd_data;
                end else begin
                    status_next = ST_MISS;
                end
            end
            OP_REMOVE: begin
                if (found[DEPTH]) begin
                    count_next = count_reg - ONE_C;
                end else begin
                    status_next = ST_MISS;
                end
            end
            default: ;
        endcase
    end

    assign count_next_w = W'(count_next);

    assign m_result_value = result_reg;
    assign m_status       = status_reg;
    assign m_entry_count  = entry_count_reg;

endmodule

FILE: hdl/blppr_checker.sv
// ----------------------------------------------------------------------------
// blppr_checker
// Port-level checks for the bounded list core, bound to the top level.
// ----------------------------------------------------------------------------
module blppr_checker
    import blppr_pkg::*;
#(
    parameter int unsigned HANDLE_WIDTH = 32
) (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic [HANDLE_WIDTH-1:0] m_result_value,
    input logic [1:0]              m_status
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_value) && $stable(m_status))
        else $error("result changed while stalled");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_OK) |-> m_result_value == '0)
        else $error("non-zero value with failing status");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a result is pending");

    a_in_then_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready && !m_valid)
        else $error("no execute cycle after input transfer");

    a_out_then_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> !m_valid && s_ready)
        else $error("not idle after output transfer");

endmodule

bind bounded_list_push_pop_remove_core blppr_checker #(
    .HANDLE_WIDTH (HANDLE_WIDTH)
) u_blppr_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_result_value (m_result_value),
    .m_status       (m_status)
);

FILE: tb/sv/blppr_list_checker.sv
// ----------------------------------------------------------------------------
// blppr_list_checker
// Watches both channels of the bounded list core and checks every result.
// Keeps its own copy of the list and the capacity. Each input transfer is
// applied to that copy and the expected result is queued. Each result
// transfer is compared field by field with the oldest queued expectation.
// ----------------------------------------------------------------------------
module blppr_list_checker
    import blppr_pkg::*;
#(
    parameter int unsigned DEPTH        = 16,
    parameter int unsigned HANDLE_WIDTH = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CAP_WIDTH-1:0]    cfg_wr_data,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic [1:0]              s_op,
    input  logic [HANDLE_WIDTH-1:0] s_item_value,
    input  logic [POS_WIDTH-1:0]    s_position,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic [HANDLE_WIDTH-1:0] m_result_value,
    input  logic [1:0]              m_status,
    input  logic [COUNT_WIDTH-1:0]  m_entry_count,
    output int                      error_count,
    output int                      results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [HANDLE_WIDTH-1:0] value;
        blppr_status_t           status;
        logic [COUNT_WIDTH-1:0]  count;
    } list_result_t;

    logic [HANDLE_WIDTH-1:0] slots [DEPTH];
    int unsigned             held;
    int unsigned             capacity;
    list_result_t            expected_results [$];

    initial begin
        error_count  = 0;
        results_owed = 0;
        held         = 0;
        capacity     = CAP_RESET;
    end

    function automatic list_result_t apply_list_op(blppr_op_t op,
                                                   logic [HANDLE_WIDTH-1:0] handle,
                                                   logic [POS_WIDTH-1:0] pos);
        list_result_t r;
        int unsigned  limit;
        int           hit;
        r.value  = '0;
        r.status = ST_OK;
        limit    = (capacity > DEPTH) ? DEPTH : capacity;
        hit      = -1;
        case (op)
            OP_PUSH: begin
                if (held >= limit) begin
                    r.status = ST_FULL;
                end else begin
                    slots[held] = handle;
                    held++;
                end
            end
            OP_POP: begin
                if (held == 0) begin
                    r.status = ST_MISS;
                end else begin
                    held--;
                    r.value = slots[held];
                end
            end
            OP_READ: begin
                if (pos < held) begin
                    r.value = slots[pos];
                end else begin
                    r.status = ST_MISS;
                end
            end
            default: begin
                for (int i = 0; i < held; i++) begin
                    if (hit < 0 && slots[i] == handle) begin
                        hit = i;
                    end
                end
                if (hit >= 0) begin
                    for (int i = hit; i + 1 < held; i++) begin
                        slots[i] = slots[i + 1];
                    end
                    held--;
                end else begin
                    r.status = ST_MISS;
                end
            end
        endcase
        r.count = COUNT_WIDTH'(held);
        return r;
    endfunction

    always @(posedge aclk) begin
        list_result_t want;
        if (!aresetn) begin
            held     = 0;
            capacity = CAP_RESET;
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no operation outstanding");
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_result_value !== want.value) begin
                        $error("result_value: expected %h, actual %h",
                               want.value, m_result_value);
                        error_count++;
                    end
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_status);
                        error_count++;
                    end
                    if (m_entry_count !== want.count) begin
                        $error("entry_count: expected %0d, actual %0d",
                               want.count, m_entry_count);
                        error_count++;
                    end
                end
            end
            if (cfg_wr_en) begin
                capacity = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(
                    apply_list_op(blppr_op_t'(s_op), s_item_value, s_position));
            end
        end
        results_owed <= expected_results.size();
    end

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the bounded list core.
// A directed opening covers empty and full lists, every operation, reads out
// of range, removal from the middle and of absent handles. Random phases then
// run under several capacities, including zero, one and above the depth,
// with bursty input transfers and a stalling receiver. Checking is done by
// the list checker instantiated beside the core.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import blppr_pkg::*;

    localparam int DEPTH           = 16;
    localparam int HANDLE_WIDTH    = 32;
    localparam int ITEMS_PER_PHASE = 72;
    localparam int NUM_PHASES      = 8;
    localparam int CYCLE_LIMIT     = 400000;

    logic                    aclk;
    logic                    aresetn        = 1'b0;
    logic                    cfg_wr_en      = 1'b0;
    logic [CAP_WIDTH-1:0]    cfg_wr_data    = '0;
    logic                    s_valid        = 1'b0;
    logic                    s_ready;
    logic [1:0]              s_op           = OP_PUSH;
    logic [HANDLE_WIDTH-1:0] s_item_value   = '0;
    logic [POS_WIDTH-1:0]    s_position     = '0;
    logic                    m_valid;
    logic                    m_ready        = 1'b0;
    logic [HANDLE_WIDTH-1:0] m_result_value;
    logic [1:0]              m_status;
    logic [COUNT_WIDTH-1:0]  m_entry_count;

    int                      failures;
    int                      results_owed;
    int                      cycle_count    = 0;
    int                      rx_tick        = 0;
    int                      rx_mode        = 0;
    int                      burst_left     = 0;
    bit                      gaps_on        = 1'b1;
    logic [HANDLE_WIDTH-1:0] recent [16];
    int                      recent_wr      = 0;

    bounded_list_push_pop_remove_core #(
        .DEPTH        (DEPTH),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_item_value   (s_item_value),
        .s_position     (s_position),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_status       (m_status),
        .m_entry_count  (m_entry_count)
    );

    blppr_list_checker #(
        .DEPTH        (DEPTH),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) list_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_item_value   (s_item_value),
        .s_position     (s_position),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_status       (m_status),
        .m_entry_count  (m_entry_count),
        .error_count    (failures),
        .results_owed   (results_owed)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver stall pattern from a mode that is picked anew at random
    always @(negedge aclk) begin
        rx_tick <= rx_tick + 1;
        if (rx_tick % 64 == 0) begin
            rx_mode <= $urandom_range(0, 3);
        end
        case (rx_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            2:       m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= ((rx_tick % 8) < 3);
        endcase
    end

    function automatic logic [HANDLE_WIDTH-1:0] pick_handle();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return HANDLE_WIDTH'($urandom_range(0, 7));
            default: return HANDLE_WIDTH'($urandom);
        endcase
    endfunction

    task automatic send_op(blppr_op_t op, logic [HANDLE_WIDTH-1:0] handle,
                           logic [POS_WIDTH-1:0] pos);
        s_valid      <= 1'b1;
        s_op         <= op;
        s_item_value <= handle;
        s_position   <= pos;
        if (op == OP_PUSH) begin
            recent[recent_wr] = handle;
            recent_wr         = (recent_wr + 1) % 16;
        end
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (gaps_on) begin
            if (burst_left == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
                burst_left = $urandom_range(1, 12);
            end else begin
                burst_left--;
            end
        end
    endtask

    // hold off until every transfer so far has produced its result
    task automatic drain();
        s_valid <= 1'b0;
        wait (results_owed == 0);
        @(negedge aclk);
    endtask

    task automatic write_capacity(logic [CAP_WIDTH-1:0] cap);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic random_op(int push_pct);
        int                      r;
        blppr_op_t               op;
        logic [HANDLE_WIDTH-1:0] h;
        r = $urandom_range(0, 99);
        h = pick_handle();
        if (r < push_pct) begin
            op = OP_PUSH;
        end else begin
            case (r % 3)
                0:       op = OP_POP;
                1:       op = OP_READ;
                default: begin
                    op = OP_REMOVE;
                    if ($urandom_range(0, 9) < 7) begin
                        h = recent[$urandom_range(0, 15)];
                    end
                end
            endcase
        end
        send_op(op, h, POS_WIDTH'($urandom_range(0, 15)));
    endtask

    initial begin
        logic [CAP_WIDTH-1:0] phase_cap [NUM_PHASES];
        int                   phase_push [NUM_PHASES];
        phase_cap  = '{5'd31, 5'd0, 5'd1, 5'd5, 5'd16, 5'd17, 5'd3, 5'd16};
        phase_push = '{50, 40, 60, 50, 60, 45, 55, 35};
        foreach (recent[i]) recent[i] = '0;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty list
        send_op(OP_POP, '0, '0);
        send_op(OP_READ, '0, 4'd0);
        send_op(OP_REMOVE, '0, '0);
        // extremes of the handle, reads in and out of range
        send_op(OP_PUSH, 32'h0000_0000, '0);
        send_op(OP_PUSH, 32'hFFFF_FFFF, '0);
        send_op(OP_PUSH, 32'hA5A5_A5A5, '0);
        send_op(OP_PUSH, 32'h5A5A_5A5A, '0);
        send_op(OP_READ, '0, 4'd3);
        send_op(OP_READ, '0, 4'd4);
        send_op(OP_READ, '0, 4'd15);
        // absent handle, then removal from the middle
        send_op(OP_REMOVE, 32'h1234_5678, '0);
        send_op(OP_REMOVE, 32'hFFFF_FFFF, '0);
        send_op(OP_READ, '0, 4'd1);
        send_op(OP_POP, '0, '0);
        send_op(OP_POP, '0, '0);
        // fill to depth with a duplicate, then refused push
        for (int k = 0; k < 15; k++) begin
            send_op(OP_PUSH, (k == 3) ? 32'h0 : 32'h1000_0000 + k, '0);
        end
        send_op(OP_PUSH, 32'hDEAD_BEEF, '0);
        send_op(OP_READ, '0, 4'd15);
        send_op(OP_REMOVE, 32'h0, '0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            write_capacity(phase_cap[p]);
            gaps_on    = (p % 3 != 1);
            burst_left = 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 99) == 0) begin
                    drain();
                end
                random_op(phase_push[p]);
            end
        end

        drain();
        repeat (8) @(negedge aclk);
        if (failures == 0 && results_owed == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
